[rtl/aip_pkg.sv]
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, constants and helpers for the ascii integer parser
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int VALUE_WIDTH_DEF  = 64;
  localparam int OFFSET_WIDTH_DEF = 16;

  localparam int BASE_W  = 6;
  localparam int DIGIT_W = 7;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // register indexes, selected by paddr[2]
  localparam logic REG_NUMBER_BASE = 1'b0;
  localparam logic REG_SIGNED_MODE = 1'b1;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic              SIGN_RESET = 1'b1;

  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd64;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 7'd10;

  // which radix the digit check uses this cycle
  typedef enum logic [1:0] {
    BSEL_PREFIX,
    BSEL_ZERO,
    BSEL_ACTIVE
  } base_sel_t;

  // what gets loaded into the active radix register
  typedef enum logic [1:0] {
    BLD_NONE,
    BLD_RAW,
    BLD_EFF,
    BLD_HEX
  } base_ld_t;

  typedef struct packed {
    base_sel_t base_sel;
    base_ld_t  base_ld;
    logic      adv;
    logic      neg_set;
    logic      digit;
    logic      finish;
    logic      stopped;
    logic      clear;
  } aip_cmd_t;

  typedef struct packed {
    logic is_nul;
    logic is_ws;
    logic is_minus;
    logic is_plus;
    logic is_zero;
    logic is_x;
    logic nb_pfx;
    logic digit_ok;
    logic ovf;
  } aip_stat_t;

  // 0-9, a-z, A-Z to 0..35; anything else to 64
  function automatic logic [DIGIT_W-1:0] digit_value(input logic [7:0] c);
    logic [DIGIT_W-1:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = DIGIT_W'(c - CH_LO_A) + DIGIT_TEN;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = DIGIT_W'(c - CH_UP_A) + DIGIT_TEN;
    end else begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

endpackage

[rtl/aip_ctrl.sv]
// ----------------------------------------------------------------------------
// aip_ctrl
// Parse phase sequencer and result handshake for the ascii integer parser
// ----------------------------------------------------------------------------
module aip_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_string_end,
  output logic              out_valid,
  input  logic              out_stall,
  input  aip_pkg::aip_stat_t stat,
  output aip_pkg::aip_cmd_t  cmd
);
  import aip_pkg::*;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS,
    PH_STOPPED,
    PH_WAIT_END
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   fire;
  logic   do_prefix;
  logic   do_digit;

  assign fire     = (phase_r != PH_WAIT_END) && (stat.is_nul || in_string_end);
  // only a transfer that produces a result needs the output register free
  assign in_stall = out_valid_r && out_stall && fire;
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    phase_nxt   = phase_r;
    cmd         = '0;
    do_prefix   = 1'b0;
    do_digit    = 1'b0;
    unique case (phase_r)
      PH_SKIP, PH_PREFIX: cmd.base_sel = BSEL_PREFIX;
      PH_ZERO:            cmd.base_sel = BSEL_ZERO;
      default:            cmd.base_sel = BSEL_ACTIVE;
    endcase

    if (accept) begin
      if (phase_r != PH_WAIT_END && !stat.is_nul) begin
        unique case (phase_r)
          PH_SKIP: begin
            if (stat.is_ws) begin
              cmd.adv = 1'b1;
            end else if (stat.is_minus) begin
              cmd.neg_set = 1'b1;
              cmd.adv     = 1'b1;
              phase_nxt   = PH_PREFIX;
            end else if (stat.is_plus) begin
              cmd.adv   = 1'b1;
              phase_nxt = PH_PREFIX;
            end else begin
              do_prefix = 1'b1;
            end
          end
          PH_PREFIX: do_prefix = 1'b1;
          PH_ZERO: begin
            if (stat.is_x) begin
              cmd.base_ld = BLD_HEX;
              cmd.adv     = 1'b1;
              phase_nxt   = PH_DIGITS;
            end else begin
              cmd.base_ld = BLD_EFF;
              phase_nxt   = PH_DIGITS;
              do_digit    = 1'b1;
            end
          end
          PH_DIGITS: do_digit = 1'b1;
          default: ;
        endcase

        if (do_prefix) begin
          if (stat.is_zero && stat.nb_pfx) begin
            cmd.base_ld = BLD_RAW;
            cmd.adv     = 1'b1;
            phase_nxt   = PH_ZERO;
          end else begin
            cmd.base_ld = BLD_EFF;
            phase_nxt   = PH_DIGITS;
            do_digit    = 1'b1;
          end
        end

        if (do_digit) begin
          cmd.digit = 1'b1;
          if (!stat.digit_ok || stat.ovf) begin
            phase_nxt = PH_STOPPED;
          end
        end
      end

      if (fire) begin
        cmd.finish  = 1'b1;
        cmd.stopped = (phase_nxt == PH_STOPPED);
        phase_nxt   = PH_WAIT_END;
      end

      if (in_string_end) begin
        cmd.clear = 1'b1;
        phase_nxt = PH_SKIP;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SKIP;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/aip_dp.sv]
// ----------------------------------------------------------------------------
// aip_dp
// Accumulator, radix, position counters and result register
// ----------------------------------------------------------------------------
module aip_dp #(
  parameter int VALUE_WIDTH  = aip_pkg::VALUE_WIDTH_DEF,
  parameter int OFFSET_WIDTH = aip_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  in_char_code,
  input  logic [aip_pkg::BASE_W-1:0]  number_base,
  input  logic                        signed_mode,
  input  aip_pkg::aip_cmd_t           cmd,
  output aip_pkg::aip_stat_t          stat,
  output logic [63:0]                 out_value_bits,
  output logic                        out_range_error,
  output logic [15:0]                 out_end_offset
);
  import aip_pkg::*;

  localparam int PROD_W = VALUE_WIDTH + BASE_W + 1;
  localparam logic [VALUE_WIDTH-1:0] HALF = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [63:0] EXT_MASK =
    ~(64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_WIDTH));

  logic [VALUE_WIDTH-1:0]  acc_r, acc_nxt;
  logic                    neg_r, neg_nxt;
  logic [BASE_W-1:0]       base_r, base_nxt;
  logic [OFFSET_WIDTH-1:0] cpos_r, cpos_nxt;
  logic [OFFSET_WIDTH-1:0] epos_r, epos_nxt;
  logic                    ovf_r, ovf_nxt;

  logic [VALUE_WIDTH-1:0]  oval_r;
  logic                    oneg_r;
  logic                    osgn_r;
  logic                    orange_r;
  logic [OFFSET_WIDTH-1:0] oend_r;

  logic [BASE_W-1:0]       eff_base;
  logic [DIGIT_W-1:0]      dval;
  logic [PROD_W-1:0]       sum;
  logic [VALUE_WIDTH-1:0]  lim;
  logic [OFFSET_WIDTH-1:0] cpos_inc;
  logic [VALUE_WIDTH-1:0]  res_val;
  logic [63:0]             res_ext;

  always_comb begin
    unique case (cmd.base_sel)
      BSEL_PREFIX: eff_base = (number_base == '0) ? BASE_DEC : number_base;
      BSEL_ZERO:   eff_base = (base_r == '0) ? BASE_OCT : base_r;
      default:     eff_base = base_r;
    endcase
  end

  assign dval = digit_value(in_char_code);
  assign lim  = signed_mode ? (neg_r ? HALF : HALF - 1'b1) : '1;
  assign sum  = PROD_W'(acc_r) * PROD_W'(eff_base) + PROD_W'(dval);

  assign stat.is_nul   = (in_char_code == CH_NUL);
  assign stat.is_ws    = (in_char_code == CH_SPACE) || (in_char_code == CH_TAB);
  assign stat.is_minus = signed_mode && (in_char_code == CH_MINUS);
  assign stat.is_plus  = (in_char_code == CH_PLUS);
  assign stat.is_zero  = (in_char_code == CH_ZERO);
  assign stat.is_x     = (in_char_code == CH_LO_X) || (in_char_code == CH_UP_X);
  assign stat.nb_pfx   = (number_base == '0) || (number_base == BASE_HEX);
  assign stat.digit_ok = dval < DIGIT_W'(eff_base);
  assign stat.ovf      = sum > PROD_W'(lim);

  assign cpos_inc = (cpos_r == '1) ? cpos_r : cpos_r + 1'b1;

  always_comb begin
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    base_nxt = base_r;
    cpos_nxt = cpos_r;
    epos_nxt = epos_r;
    ovf_nxt  = ovf_r;
    if (cmd.adv) begin
      cpos_nxt = cpos_inc;
    end
    if (cmd.neg_set) begin
      neg_nxt = 1'b1;
    end
    unique case (cmd.base_ld)
      BLD_RAW:  base_nxt = number_base;
      BLD_EFF:  base_nxt = eff_base;
      BLD_HEX:  base_nxt = BASE_HEX;
      default:  base_nxt = base_r;
    endcase
    if (cmd.digit) begin
      if (stat.digit_ok && !stat.ovf) begin
        acc_nxt  = sum[VALUE_WIDTH-1:0];
        cpos_nxt = cpos_inc;
      end else begin
        // stop here; overflow also saturates
        epos_nxt = cpos_r;
        if (stat.digit_ok) begin
          ovf_nxt = 1'b1;
          acc_nxt = lim;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      acc_r  <= '0;
      neg_r  <= 1'b0;
      base_r <= '0;
      cpos_r <= '0;
      epos_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
      base_r <= base_nxt;
      cpos_r <= cpos_nxt;
      epos_r <= epos_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      oval_r   <= acc_nxt;
      oneg_r   <= neg_nxt;
      osgn_r   <= signed_mode;
      orange_r <= ovf_nxt;
      oend_r   <= cmd.stopped ? epos_nxt : cpos_nxt;
    end
  end

  // sign applied after the result register
  assign res_val = (osgn_r && oneg_r) ? (~oval_r + 1'b1) : oval_r;
  assign res_ext = (osgn_r && res_val[VALUE_WIDTH-1]) ?
                   (64'(res_val) | EXT_MASK) : 64'(res_val);

  assign out_value_bits  = res_ext;
  assign out_range_error = orange_r;
  assign out_end_offset  = 16'(oend_r);

endmodule

[rtl/ascii_integer_parser.sv]
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming string to integer converter with radix detection and saturation
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_char_code, in_string_end
//  out     | output    | out_valid/out_stall| out_value_bits, out_range_error,
//          |           |                    | out_end_offset
//  cfg     | input     | psel/penable/pready| paddr, pwdata, pwrite, prdata
//
// One character is taken every cycle while in_stall is low; the
// multiply-add-compare on the accumulator is the combinational path for this.
// out_valid rises in the cycle after the NUL or string_end character is taken.
// Reset is synchronous on rst_n and returns to the whitespace phase.
// in_stall rises only when a terminating character meets a held result.
// ----------------------------------------------------------------------------
module ascii_integer_parser #(
  parameter int VALUE_WIDTH  = aip_pkg::VALUE_WIDTH_DEF,
  parameter int OFFSET_WIDTH = aip_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_char_code,
  input  logic                        in_string_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [63:0]                 out_value_bits,
  output logic                        out_range_error,
  output logic [15:0]                 out_end_offset,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aip_pkg::ADDR_W-1:0]  paddr,
  input  logic [aip_pkg::DATA_W-1:0]  pwdata,
  output logic [aip_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import aip_pkg::*;

  logic [BASE_W-1:0] number_base_r;
  logic              signed_mode_r;
  logic              reg_sel;
  logic              cfg_wr;
  aip_cmd_t          cmd;
  aip_stat_t         stat;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_RESET;
      signed_mode_r <= SIGN_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == REG_NUMBER_BASE) begin
        number_base_r <= pwdata[BASE_W-1:0];
      end else begin
        signed_mode_r <= pwdata[0];
      end
    end
  end

  assign prdata = (reg_sel == REG_NUMBER_BASE) ? DATA_W'(number_base_r)
                                               : DATA_W'(signed_mode_r);

  aip_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_string_end (in_string_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .stat          (stat),
    .cmd           (cmd)
  );

  aip_dp #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_char_code    (in_char_code),
    .number_base     (number_base_r),
    .signed_mode     (signed_mode_r),
    .cmd             (cmd),
    .stat            (stat),
    .out_value_bits  (out_value_bits),
    .out_range_error (out_range_error),
    .out_end_offset  (out_end_offset)
  );

endmodule

[dv/ascii_integer_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_integer_parser_tb
// Streams directed and random strings through the parser with random gaps on
// both channels. Results come from a behavioral model of the parse or from
// the directed table; each is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module ascii_integer_parser_tb;
  import aip_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int WATCHDOG     = 1000;

  localparam logic [ADDR_W-1:0] ADDR_BASE = {REG_NUMBER_BASE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SIGN = {REG_SIGNED_MODE, 2'b00};

  localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] OFFS_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    PS_SKIP,
    PS_PREFIX,
    PS_ZERO,
    PS_DIGITS,
    PS_STOPPED,
    PS_WAIT_END
  } parse_state_t;

  // how a string is closed: string_end on its last char, a NUL, or a NUL
  // followed by junk that must be ignored
  typedef enum int {
    TERM_END,
    TERM_NUL,
    TERM_NUL_TAIL
  } term_t;

  typedef struct packed {
    logic [63:0] value;
    logic        rng;
    logic [15:0] offs;
  } parse_res_t;

  typedef struct {
    logic [5:0] base;
    logic       sgn;
    string      text;
    term_t      term;
    bit         typed;
    parse_res_t res;
  } dir_row_t;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [7:0]          in_char_code    = '0;
  logic                in_string_end   = 1'b0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [63:0]         out_value_bits;
  logic                out_range_error;
  logic [15:0]         out_end_offset;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [ADDR_W-1:0]   paddr           = '0;
  logic [DATA_W-1:0]   pwdata          = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  ascii_integer_parser DUT (.*);

  always #6 clk = ~clk;

  // parser model state and its copy of the registers
  logic [5:0]   cur_base   = BASE_RESET;
  logic         cur_signed = SIGN_RESET;
  parse_state_t ps         = PS_SKIP;
  logic [63:0]  acc        = '0;
  logic         neg        = 1'b0;
  logic [5:0]   radix      = '0;
  logic [15:0]  pos        = '0;
  logic [15:0]  stop_pos   = '0;
  logic         ovf        = 1'b0;

  parse_res_t   expected_results[$];
  parse_res_t   typed_res;
  bit           typed_armed = 1'b0;
  bit           quiet       = 1'b0;
  int           err_cnt     = 0;
  int           items_sent  = 0;
  int           stuck_cycles = 0;
  int           hold_cnt    = 0;
  dir_row_t     dir_rows[$];

  function automatic void clear_string();
    ps       = PS_SKIP;
    acc      = '0;
    neg      = 1'b0;
    radix    = '0;
    pos      = '0;
    stop_pos = '0;
    ovf      = 1'b0;
  endfunction

  function automatic void bump_pos();
    if (pos != OFFS_MAX) begin
      pos++;
    end
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    logic [6:0]  d;
    logic [63:0] lim;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 7'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = 7'(c - CH_LO_A) + DIGIT_TEN;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = 7'(c - CH_UP_A) + DIGIT_TEN;
    end else begin
      d = DIGIT_NONE;
    end
    if (!cur_signed) begin
      lim = ALL_ONES;
    end else if (neg) begin
      lim = NEG_MAX;
    end else begin
      lim = POS_MAX;
    end
    if (d >= 7'(radix)) begin
      ps       = PS_STOPPED;
      stop_pos = pos;
    end else if (acc > (lim - 64'(d)) / 64'(radix)) begin
      // saturate and leave the offset on the digit that overflowed
      ovf      = 1'b1;
      acc      = lim;
      ps       = PS_STOPPED;
      stop_pos = pos;
    end else begin
      acc = acc * 64'(radix) + 64'(d);
      bump_pos();
    end
  endfunction

  // first char past whitespace and sign: the radix register is latched here
  function automatic void take_prefix(input logic [7:0] c);
    radix = cur_base;
    if (c == CH_ZERO && (radix == 0 || radix == BASE_HEX)) begin
      bump_pos();
      ps = PS_ZERO;
    end else begin
      if (radix == 0) begin
        radix = BASE_DEC;
      end
      ps = PS_DIGITS;
      take_digit(c);
    end
  endfunction

  function automatic void close_string(output parse_res_t r);
    if (ps != PS_STOPPED) begin
      stop_pos = pos;
    end
    r.value = (cur_signed && neg) ? -acc : acc;
    r.rng   = ovf;
    r.offs  = stop_pos;
    ps      = PS_WAIT_END;
  endfunction

  function automatic bit parse_char(input logic [7:0] c, input logic last,
                                    output parse_res_t r);
    bit hit;
    hit = 1'b0;
    r   = '0;
    if (ps != PS_WAIT_END) begin
      if (c == CH_NUL) begin
        close_string(r);
        hit = 1'b1;
      end else begin
        case (ps)
          PS_SKIP: begin
            if (c == CH_SPACE || c == CH_TAB) begin
              bump_pos();
            end else if (cur_signed && c == CH_MINUS) begin
              neg = 1'b1;
              bump_pos();
              ps = PS_PREFIX;
            end else if (c == CH_PLUS) begin
              bump_pos();
              ps = PS_PREFIX;
            end else begin
              take_prefix(c);
            end
          end
          PS_PREFIX: begin
            take_prefix(c);
          end
          PS_ZERO: begin
            if (c == CH_LO_X || c == CH_UP_X) begin
              radix = BASE_HEX;
              bump_pos();
              ps = PS_DIGITS;
            end else begin
              if (radix == 0) begin
                radix = BASE_OCT;
              end
              ps = PS_DIGITS;
              take_digit(c);
            end
          end
          PS_DIGITS: begin
            take_digit(c);
          end
          default: begin
          end
        endcase
      end
    end
    if (last) begin
      if (!hit && ps != PS_WAIT_END) begin
        close_string(r);
        hit = 1'b1;
      end
      clear_string();
    end
    return hit;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (rst_n && !quiet && $urandom_range(0, 99) < 30) begin
      out_stall <= 1'b1;
      hold_cnt  <= idle_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    parse_res_t pred;
    parse_res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (parse_char(in_char_code, in_string_end, pred)) begin
          if (typed_armed) begin
            expected_results.push_back(typed_res);
            typed_armed = 1'b0;
          end else begin
            expected_results.push_back(pred);
          end
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: value_bits %h", out_value_bits);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_value_bits !== want.value) begin
            $error("value_bits: expected %h, got %h", want.value, out_value_bits);
            err_cnt++;
          end
          if (out_range_error !== want.rng) begin
            $error("range_error: expected %b, got %b", want.rng, out_range_error);
            err_cnt++;
          end
          if (out_end_offset !== want.offs) begin
            $error("end_offset: expected %0d, got %0d", want.offs, out_end_offset);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_char_code  <= c;
    in_string_end <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_text(input byte unsigned txt[$], input term_t tm);
    int    n;
    int    tail;
    term_t t;
    n = txt.size();
    t = (tm == TERM_END && n == 0) ? TERM_NUL : tm;
    for (int k = 0; k < n; k++) begin
      send_char(txt[k], t == TERM_END && k == n - 1);
    end
    items_sent += n;
    if (t != TERM_END) begin
      send_char(CH_NUL, t == TERM_NUL);
      items_sent++;
      if (t == TERM_NUL_TAIL) begin
        tail = $urandom_range(1, 3);
        for (int k = 0; k < tail; k++) begin
          send_char(8'($urandom_range(0, 255)), k == tail - 1);
        end
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (a == ADDR_BASE) begin
      cur_base = d[5:0];
    end else begin
      cur_signed = d[0];
    end
  endtask

  task automatic set_config(input logic [5:0] b, input logic s);
    logic [DATA_W-1:0] w;
    wait_idle();
    // unused upper bits carry noise
    w      = $urandom();
    w[5:0] = b;
    cfg_write(ADDR_BASE, w);
    w    = $urandom();
    w[0] = s;
    cfg_write(ADDR_SIGN, w);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic void add_row(input logic [5:0] b, input logic s, input string t,
                                  input term_t tm, input bit ty, input logic [63:0] v,
                                  input logic r, input logic [15:0] o);
    dir_row_t row;
    row.base  = b;
    row.sgn   = s;
    row.text  = t;
    row.term  = tm;
    row.typed = ty;
    row.res   = '{value: v, rng: r, offs: o};
    dir_rows.push_back(row);
  endfunction

  initial begin
    byte unsigned txt[$];
    dir_row_t     row;
    logic [5:0]   rb;
    int           pick;
    int           n;
    int           d;
    int           radix_hint;
    int           strings_left;
    term_t        tm;

    // first rows run on the reset register values
    add_row(6'd10, 1'b1, "0", TERM_END, 1, '0, 1'b0, 16'd1);
    add_row(6'd10, 1'b1, "  \t-42xyz", TERM_NUL_TAIL, 1, 64'hFFFF_FFFF_FFFF_FFD6, 1'b0, 16'd6);
    add_row(6'd10, 1'b1, "9223372036854775807", TERM_END, 1, POS_MAX, 1'b0, 16'd19);
    add_row(6'd10, 1'b1, "-9223372036854775808", TERM_NUL, 1, NEG_MAX, 1'b0, 16'd20);
    add_row(6'd10, 1'b1, "9223372036854775808", TERM_END, 1, POS_MAX, 1'b1, 16'd18);
    add_row(6'd10, 1'b1, "-99999999999999999999", TERM_END, 1, NEG_MAX, 1'b1, 16'd19);
    add_row(6'd10, 1'b1, "+", TERM_END, 1, '0, 1'b0, 16'd1);
    add_row(6'd10, 1'b1, "\t\t+0099 ", TERM_END, 0, '0, 1'b0, '0);
    add_row(6'd0, 1'b1, "0x1F", TERM_END, 0, '0, 1'b0, '0);
    add_row(6'd0, 1'b1, "017", TERM_NUL, 0, '0, 1'b0, '0);
    add_row(6'd0, 1'b1, "0x", TERM_END, 1, '0, 1'b0, 16'd2);
    add_row(6'd0, 1'b1, "09", TERM_END, 1, '0, 1'b0, 16'd1);
    add_row(BASE_HEX, 1'b1, "0XfF", TERM_END, 0, '0, 1'b0, '0);
    add_row(BASE_HEX, 1'b1, "-0x8000000000000000", TERM_END, 1, NEG_MAX, 1'b0, 16'd19);
    add_row(6'd0, 1'b0, "18446744073709551615", TERM_END, 1, ALL_ONES, 1'b0, 16'd20);
    add_row(6'd0, 1'b0, "18446744073709551616", TERM_END, 1, ALL_ONES, 1'b1, 16'd19);
    add_row(6'd0, 1'b0, "-5", TERM_END, 1, '0, 1'b0, 16'd0);
    add_row(6'd0, 1'b0, "+7", TERM_NUL, 1, 64'd7, 1'b0, 16'd2);
    add_row(6'd1, 1'b1, "0010", TERM_NUL_TAIL, 1, '0, 1'b0, 16'd2);
    add_row(6'd36, 1'b0, "zZ", TERM_END, 0, '0, 1'b0, '0);
    add_row(6'd63, 1'b0, "Zz!", TERM_END, 0, '0, 1'b0, '0);
    add_row(6'd2, 1'b1, "", TERM_NUL, 1, '0, 1'b0, 16'd0);
    add_row(6'd2, 1'b1, "1\377", TERM_END, 1, 64'd1, 1'b0, 16'd1);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.base != cur_base || row.sgn != cur_signed) begin
        set_config(row.base, row.sgn);
      end
      txt = {};
      for (int k = 0; k < row.text.len(); k++) begin
        txt.push_back(row.text[k]);
      end
      if (row.typed) begin
        typed_res   = row.res;
        typed_armed = 1'b1;
      end
      send_text(txt, row.term);
    end

    strings_left = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (strings_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          rb = '0;
        end else if (pick < 40) begin
          rb = BASE_DEC;
        end else if (pick < 55) begin
          rb = BASE_HEX;
        end else if (pick < 62) begin
          rb = BASE_OCT;
        end else if (pick < 67) begin
          rb = 6'd2;
        end else if (pick < 72) begin
          rb = 6'd36;
        end else if (pick < 76) begin
          rb = 6'd1;
        end else if (pick < 80) begin
          rb = 6'd63;
        end else begin
          rb = 6'($urandom_range(0, 63));
        end
        set_config(rb, 1'($urandom_range(0, 1)));
        strings_left = $urandom_range(4, 20);
      end
      strings_left--;
      quiet = ($urandom_range(0, 7) == 0);
      txt   = {};
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(0, 3)) txt.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
          txt.push_back(CH_MINUS);
        end else if (pick == 1) begin
          txt.push_back(CH_PLUS);
        end
        // radix the digits below are drawn for
        radix_hint = (cur_base > 36) ? 36 : int'(cur_base);
        if (cur_base == 0 || cur_base == BASE_HEX) begin
          pick = $urandom_range(0, 2);
          if (pick == 2) begin
            txt.push_back(CH_ZERO);
            txt.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            radix_hint = 16;
          end else if (pick == 1 && cur_base == 0) begin
            txt.push_back(CH_ZERO);
            radix_hint = 8;
          end else if (cur_base == 0) begin
            radix_hint = 10;
          end
        end
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          n = $urandom_range(1, 6);
        end else if (pick < 95) begin
          n = $urandom_range(7, 20);
        end else begin
          n = $urandom_range(21, 40);
        end
        for (int k = 0; k < n; k++) begin
          if (n > 20) begin
            d = radix_hint - 1;
          end else if ($urandom_range(0, 19) == 0) begin
            d = $urandom_range(0, 35);
          end else begin
            d = $urandom_range(0, radix_hint - 1);
          end
          if (d < 10) begin
            txt.push_back(8'(CH_ZERO + d));
          end else begin
            txt.push_back(8'(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + d - 10));
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(1, 255)));
        end
      end
      pick = $urandom_range(0, 9);
      tm   = (pick < 5) ? TERM_END : (pick < 8) ? TERM_NUL : TERM_NUL_TAIL;
      send_text(txt, tm);
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
